>>> design/rtdb_pkg.sv
// ----------------------------------------------------------------------------
// rtdb_pkg
// Shared types and constants for the RTD bridge code-to-temperature core.
// ----------------------------------------------------------------------------
package rtdb_pkg;

   localparam int ADC_CODE_W  = 18;
   localparam int TEMP_W      = 21;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam int GAIN_W   = 2;
   localparam int RES_W    = 16;
   localparam int SUPPLY_W = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN   = 8'd0,
      CSR_BRIDGE = 8'd1,
      CSR_LIMIT  = 8'd2,
      CSR_SUPPLY = 8'd3
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NEG_DISC = 2'd1,
      STATUS_BAD      = 2'd2
   } status_type;

   // register defaults, also used when a register holds zero
   localparam logic [RES_W-1:0]    BRIDGE_DFLT = 16'd100;
   localparam logic [RES_W-1:0]    LIMIT_DFLT  = 16'd1500;
   localparam logic [SUPPLY_W-1:0] SUPPLY_DFLT = 4'd3;

   // derived values at reset defaults
   localparam logic [19:0] SVBR_RST = 20'd300;
   localparam logic [39:0] BASE_RST = 40'd300000000;
   localparam logic [23:0] SVM_RST  = 24'd3000000;
   localparam logic [17:0] M3_RST   = 18'd4600;
   localparam logic [16:0] K_RST    = 17'd16;

   localparam logic [19:0] MICRO    = 20'd1000000;
   localparam int          DEN_W    = 24;
   localparam int          RQ_W     = 31;
   localparam logic [RQ_W-1:0] RQ_MAX = 31'h7FFF_FFFF;
   localparam logic [32:0] RQ_R0    = 33'd6553600;
   localparam logic [63:0] D_AA     = 64'd97758776896000000;
   localparam logic [31:0] D_SLOPE  = 32'd2255859375;
   localparam logic [31:0] Q_A      = 32'd2501312000;
   localparam int          ROOT_W   = 32;

   // rounding divide by 3696 = 16 * 231; reciprocal of 231 at 2^38
   localparam logic [34:0] ROUND_HALF = 35'd1848;
   localparam logic [30:0] RECIP_M    = 31'd1189947650;
   localparam int          RECIP_SH   = 38;

   localparam logic signed [23:0] TEMP_MAX     = 24'sd1000000;
   localparam logic signed [23:0] TEMP_MIN     = -24'sd250000;
   localparam logic [TEMP_W-1:0]  INVALID_TEMP = 21'd65535;

endpackage

>>> design/rtdb_if.sv
// ----------------------------------------------------------------------------
// rtdb_if
// Request, response and register-write channels of the RTD bridge core.
// ----------------------------------------------------------------------------
interface rtdb_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [rtdb_pkg::ADC_CODE_W-1:0]    adc_code;
   modport source (output valid, output adc_code, input ready);
   modport sink   (input valid, input adc_code, output ready);
endinterface

interface rtdb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rtdb_pkg::TEMP_W-1:0]  temperature_milli_c;
   logic [rtdb_pkg::STATUS_W-1:0]       status;
   modport source (output valid, output temperature_milli_c, output status, input ready);
   modport sink   (input valid, input temperature_milli_c, input status, output ready);
endinterface

interface rtdb_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [rtdb_pkg::CSR_INDEX_W-1:0]     index;
   logic [rtdb_pkg::CSR_DATA_W-1:0]      wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> design/rtdb_div.sv
// ----------------------------------------------------------------------------
// rtdb_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rtdb_div #(
   parameter int QW = 31,
   parameter int DW = 24,
   parameter int TW = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [DW-1:0] in_den,
   input  logic [QW-1:0] in_lo,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QW-1:0] out_quot,
   output logic [TW-1:0] out_tag
);
   logic          v_ff   [QW];
   logic [DW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] q_ff   [QW];
   logic [TW-1:0] tag_ff [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic          v_p;
      logic [DW-1:0] rem_p;
      logic [DW-1:0] den_p;
      logic [QW-1:0] q_p;
      logic [TW-1:0] tag_p;
      logic [DW:0]   t;
      logic          ge;

      if (i == 0) begin : g_first
         assign v_p   = in_valid;
         assign rem_p = in_rem;
         assign den_p = in_den;
         assign q_p   = in_lo;
         assign tag_p = in_tag;
      end else begin : g_next
         assign v_p   = v_ff[i-1];
         assign rem_p = rem_ff[i-1];
         assign den_p = den_ff[i-1];
         assign q_p   = q_ff[i-1];
         assign tag_p = tag_ff[i-1];
      end

      assign t  = {rem_p, q_p[QW-1]};
      assign ge = (t >= {1'b0, den_p});

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= ge ? DW'(t - {1'b0, den_p}) : t[DW-1:0];
            q_ff[i]   <= {q_p[QW-2:0], ge};
            den_ff[i] <= den_p;
            tag_ff[i] <= tag_p;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_quot  = q_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

>>> design/rtdb_sqrt.sv
// ----------------------------------------------------------------------------
// rtdb_sqrt
// Pipelined integer square root, one root bit per stage (floor result).
// ----------------------------------------------------------------------------
module rtdb_sqrt #(
   parameter int RW = 32,
   parameter int TW = 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_rad,
   input  logic [TW-1:0]   in_tag,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [TW-1:0]   out_tag
);
   logic            v_ff    [RW];
   logic [RW:0]     rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [2*RW-1:0] rad_ff  [RW];
   logic [TW-1:0]   tag_ff  [RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic            v_p;
      logic [RW:0]     rem_p;
      logic [RW-1:0]   root_p;
      logic [2*RW-1:0] rad_p;
      logic [TW-1:0]   tag_p;
      logic [RW+2:0]   r4;
      logic [RW+2:0]   trial;
      logic            ge;

      if (i == 0) begin : g_first
         assign v_p    = in_valid;
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = in_rad;
         assign tag_p  = in_tag;
      end else begin : g_next
         assign v_p    = v_ff[i-1];
         assign rem_p  = rem_ff[i-1];
         assign root_p = root_ff[i-1];
         assign rad_p  = rad_ff[i-1];
         assign tag_p  = tag_ff[i-1];
      end

      assign r4    = {rem_p, rad_p[2*RW-1:2*RW-2]};
      assign trial = {1'b0, root_p, 2'b01};
      assign ge    = (r4 >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? (RW+1)'(r4 - trial) : r4[RW:0];
            root_ff[i] <= {root_p[RW-2:0], ge};
            rad_ff[i]  <= {rad_p[2*RW-3:0], 2'b00};
            tag_ff[i]  <= tag_p;
         end
      end
   end

   assign out_valid = v_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_tag   = tag_ff[RW-1];

endmodule

>>> design/rtd_bridge_code_to_temperature_core.sv
// ----------------------------------------------------------------------------
// rtd_bridge_code_to_temperature_core
// PT100 bridge ADC code to temperature in millidegrees C, fully pipelined.
// Throughput: one request per cycle while no register write and no response
// stall holds it; the 31-stage divider and 32-stage root each retire one bit
// per stage. A register write stalls requests while the bridge ratio is
// divided out serially. Reset restores register defaults and empties the pipe.
// ----------------------------------------------------------------------------
module rtd_bridge_code_to_temperature_core #(
   parameter int ADC_BITS = 18
) (
   input  logic          clock,
   input  logic          reset,
   rtdb_req_if.sink      req_bus,
   rtdb_rsp_if.source    rsp_bus,
   rtdb_csr_if.sink      csr_bus
);
   import rtdb_pkg::*;

   localparam int VW   = ADC_BITS + 3;
   localparam int PAW  = VW + 18;
   localparam int KVW  = VW + 17;
   localparam int NUMW = ((PAW + 1) > 40 ? (PAW + 1) : 40) + 1;
   localparam int DENW = KVW + 2;
   localparam int XW   = NUMW + 17;
   localparam int HIW  = XW - RQ_W;

   // ---------------- registers and derived constants ----------------
   logic [GAIN_W-1:0]   gain_ff;
   logic [RES_W-1:0]    bridge_ff;
   logic [RES_W-1:0]    limit_ff;
   logic [SUPPLY_W-1:0] supply_ff;
   logic [RES_W-1:0]    br_e;
   logic [RES_W-1:0]    lr_e;
   logic [SUPPLY_W-1:0] sv_e;
   logic [19:0]         svbr_ff;
   logic [39:0]         base_ff;
   logic [23:0]         svm_ff;
   logic [17:0]         m3_ff;
   logic                csr_wr;

   assign csr_bus.ready = 1'b1;
   assign csr_wr = csr_bus.valid;

   assign br_e = (bridge_ff == '0) ? BRIDGE_DFLT : bridge_ff;
   assign lr_e = (limit_ff == '0)  ? LIMIT_DFLT  : limit_ff;
   assign sv_e = (supply_ff == '0) ? SUPPLY_DFLT : supply_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= '0;
         bridge_ff <= BRIDGE_DFLT;
         limit_ff  <= LIMIT_DFLT;
         supply_ff <= SUPPLY_DFLT;
      end else if (csr_wr) begin
         unique case (csr_bus.index)
            CSR_GAIN:   gain_ff   <= csr_bus.wdata[GAIN_W-1:0];
            CSR_BRIDGE: bridge_ff <= csr_bus.wdata[RES_W-1:0];
            CSR_LIMIT:  limit_ff  <= csr_bus.wdata[RES_W-1:0];
            CSR_SUPPLY: supply_ff <= csr_bus.wdata[SUPPLY_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         svbr_ff <= SVBR_RST;
         base_ff <= BASE_RST;
         svm_ff  <= SVM_RST;
         m3_ff   <= M3_RST;
      end else begin
         svbr_ff <= 20'(sv_e) * 20'(br_e);
         base_ff <= 40'(svbr_ff) * 40'(MICRO);
         svm_ff  <= 24'(sv_e) * 24'(MICRO);
         m3_ff   <= 18'(lr_e) * 18'd3 + 18'(br_e);
      end
   end

   // serial divide: k = (limit + bridge) / bridge
   logic [16:0] kq_ff;
   logic [15:0] krem_ff;
   logic [4:0]  kcnt_ff;
   logic        kstart_ff;
   logic        busy_ff;
   logic [16:0] kt;
   logic        kge;

   assign kt  = {krem_ff, kq_ff[16]};
   assign kge = (kt >= {1'b0, br_e});

   always_ff @(posedge clock) begin
      if (reset) begin
         kq_ff     <= K_RST;
         kcnt_ff   <= '0;
         kstart_ff <= 1'b0;
         busy_ff   <= 1'b0;
      end else if (csr_wr) begin
         kstart_ff <= 1'b1;
         busy_ff   <= 1'b1;
      end else if (kstart_ff) begin
         kq_ff     <= 17'(lr_e) + 17'(br_e);
         kcnt_ff   <= 5'd17;
         kstart_ff <= 1'b0;
      end else if (kcnt_ff != '0) begin
         kq_ff   <= {kq_ff[15:0], kge};
         kcnt_ff <= kcnt_ff - 5'd1;
         if (kcnt_ff == 5'd1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (kstart_ff) begin
         krem_ff <= '0;
      end else if (kcnt_ff != '0) begin
         krem_ff <= kge ? 16'(kt - {1'b0, br_e}) : kt[15:0];
      end
   end

   // ---------------- pipeline control ----------------
   logic en;
   logic acc;
   logic rsp_v_ff;

   assign en            = ~rsp_v_ff | rsp_bus.ready;
   assign req_bus.ready = en & ~busy_ff;
   assign acc           = req_bus.valid & req_bus.ready;

   // stage 1: microvolts
   logic [23:0]          code_ext;
   logic [ADC_BITS-1:0]  raw;
   logic [ADC_BITS+6:0]  r125;
   logic                 s1_v_ff;
   logic                 s1_bad_ff;
   logic [VW-1:0]        s1_uv_ff;

   assign code_ext = {{(24-ADC_CODE_W){req_bus.adc_code[ADC_CODE_W-1]}}, req_bus.adc_code};
   assign raw      = code_ext[ADC_BITS-1:0];
   assign r125     = (ADC_BITS+7)'(raw) * (ADC_BITS+7)'(125);

   // stage 2: products
   logic               s2_v_ff;
   logic               s2_bad_ff;
   logic [PAW-1:0]     s2_pa_ff;
   logic [KVW-1:0]     s2_kv_ff;

   // stage 3: numerator and denominator
   logic                   s3_v_ff;
   logic                   s3_bad_ff;
   logic [NUMW-1:0]        s3_num_ff;
   logic signed [DENW-1:0] s3_den_ff;
   logic [NUMW-1:0]        num_c;
   logic signed [DENW-1:0] den_c;

   assign num_c = (NUMW'(s2_pa_ff) << 1) + NUMW'(base_ff);
   assign den_c = $signed(DENW'(svm_ff)) - $signed(DENW'(s2_kv_ff) << 1);

   // stage 4: dividend split and range check
   logic [XW-1:0]     x_c;
   logic [HIW-1:0]    hi_c;
   logic              s4_v_ff;
   logic [1:0]        s4_tag_ff;
   logic [DEN_W-1:0]  s4_rem_ff;
   logic [DEN_W-1:0]  s4_den_ff;
   logic [RQ_W-1:0]   s4_lo_ff;

   assign x_c  = (XW'(s3_num_ff) << 16) + XW'(s3_den_ff[DEN_W-1:1]);
   assign hi_c = x_c[XW-1:RQ_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= acc;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_bad_ff <= raw[ADC_BITS-1];
         s1_uv_ff  <= VW'(r125 >> 3) >> gain_ff;
         s2_bad_ff <= s1_bad_ff;
         s2_pa_ff  <= PAW'(s1_uv_ff) * PAW'(m3_ff);
         s2_kv_ff  <= KVW'(s1_uv_ff) * KVW'(kq_ff);
         s3_bad_ff <= s2_bad_ff | den_c[DENW-1] | (den_c == '0);
         s3_num_ff <= num_c;
         s3_den_ff <= den_c;
         s4_tag_ff <= {s3_bad_ff, (hi_c >= HIW'(s3_den_ff[DEN_W-1:0]))};
         s4_rem_ff <= hi_c[DEN_W-1:0];
         s4_den_ff <= s3_den_ff[DEN_W-1:0];
         s4_lo_ff  <= x_c[RQ_W-1:0];
      end
   end

   // resistance Q15.16
   logic            dv_v;
   logic [RQ_W-1:0] dv_q;
   logic [1:0]      dv_tag;

   rtdb_div #(.QW(RQ_W), .DW(DEN_W), .TW(2)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_v_ff),
      .in_rem    (s4_rem_ff),
      .in_den    (s4_den_ff),
      .in_lo     (s4_lo_ff),
      .in_tag    (s4_tag_ff),
      .out_valid (dv_v),
      .out_quot  (dv_q),
      .out_tag   (dv_tag)
   );

   // stage 5: offset from R0
   logic               s5_v_ff;
   logic               s5_bad_ff;
   logic signed [32:0] s5_diff_ff;
   logic [RQ_W-1:0]    rq_c;

   assign rq_c = dv_tag[0] ? RQ_MAX : dv_q;

   // stage 6: partial products of slope
   logic               s6_v_ff;
   logic               s6_bad_ff;
   logic [47:0]        s6_pl_ff;
   logic signed [49:0] s6_ph_ff;

   // stage 7: discriminant
   logic               s7_v_ff;
   logic [1:0]         s7_tag_ff;
   logic [63:0]        s7_rad_ff;
   logic signed [66:0] prod_c;
   logic signed [66:0] disc_c;

   assign prod_c = ($signed(67'(s6_ph_ff)) <<< 16) + $signed(67'(s6_pl_ff));
   assign disc_c = $signed(67'(D_AA)) - prod_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
      end else if (en) begin
         s5_v_ff <= dv_v;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_bad_ff  <= dv_tag[1];
         s5_diff_ff <= $signed({2'b00, rq_c}) - $signed(RQ_R0);
         s6_bad_ff  <= s5_bad_ff;
         s6_pl_ff   <= 48'(D_SLOPE) * 48'(s5_diff_ff[15:0]);
         s6_ph_ff   <= 50'($signed({1'b0, D_SLOPE}) * $signed(s5_diff_ff[32:16]));
         s7_tag_ff  <= {s6_bad_ff, disc_c[66]};
         s7_rad_ff  <= {disc_c[56:0], 7'b0} >> 1;
      end
   end

   // root: 8e10 * sqrt(disc), 3 fractional bits
   logic              sq_v;
   logic [ROOT_W-1:0] sq_r;
   logic [1:0]        sq_tag;

   rtdb_sqrt #(.RW(ROOT_W), .TW(2)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s7_v_ff),
      .in_rad    (s7_rad_ff),
      .in_tag    (s7_tag_ff),
      .out_valid (sq_v),
      .out_root  (sq_r),
      .out_tag   (sq_tag)
   );

   // stage 8..10: rounded divide by 3696
   logic               s8_v_ff;
   logic [1:0]         s8_tag_ff;
   logic signed [35:0] s8_n_ff;
   logic signed [35:0] qd_c;
   logic               s9_v_ff;
   logic [1:0]         s9_tag_ff;
   logic               s9_neg_ff;
   logic [29:0]        s9_ah_ff;
   logic [35:0]        mag_c;
   logic [35:0]        a_c;
   logic               s10_v_ff;
   logic [1:0]         s10_tag_ff;
   logic               s10_neg_ff;
   logic [60:0]        s10_p_ff;

   assign qd_c  = $signed({4'b0, Q_A}) - $signed({4'b0, sq_r});
   assign mag_c = s8_n_ff[35] ? 36'(-s8_n_ff) : 36'(s8_n_ff);
   assign a_c   = mag_c + 36'(ROUND_HALF);

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_v_ff  <= 1'b0;
         s9_v_ff  <= 1'b0;
         s10_v_ff <= 1'b0;
      end else if (en) begin
         s8_v_ff  <= sq_v;
         s9_v_ff  <= s8_v_ff;
         s10_v_ff <= s9_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_tag_ff  <= sq_tag;
         s8_n_ff    <= (qd_c <<< 2) + qd_c;
         s9_tag_ff  <= s8_tag_ff;
         s9_neg_ff  <= s8_n_ff[35];
         s9_ah_ff   <= a_c[33:4];
         s10_tag_ff <= s9_tag_ff;
         s10_neg_ff <= s9_neg_ff;
         s10_p_ff   <= 61'(s9_ah_ff) * 61'(RECIP_M);
      end
   end

   // output stage: sign, clamp, status
   logic [22:0]         qt_c;
   logic signed [23:0]  t_c;
   logic signed [23:0]  tc_c;
   status_type          st_c;
   logic [TEMP_W-1:0]   rsp_t_ff;
   status_type          rsp_st_ff;

   assign qt_c = s10_p_ff[RECIP_SH+22:RECIP_SH];
   assign t_c  = s10_neg_ff ? -$signed({1'b0, qt_c}) : $signed({1'b0, qt_c});

   always_comb begin
      tc_c = t_c;
      if (t_c > TEMP_MAX) begin
         tc_c = TEMP_MAX;
      end else if (t_c < TEMP_MIN) begin
         tc_c = TEMP_MIN;
      end
      if (s10_tag_ff[1]) begin
         st_c = STATUS_BAD;
      end else if (s10_tag_ff[0]) begin
         st_c = STATUS_NEG_DISC;
      end else begin
         st_c = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= s10_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_st_ff <= st_c;
         rsp_t_ff  <= (st_c == STATUS_OK) ? tc_c[TEMP_W-1:0] : INVALID_TEMP;
      end
   end

   assign rsp_bus.valid               = rsp_v_ff;
   assign rsp_bus.temperature_milli_c = $signed(rsp_t_ff);
   assign rsp_bus.status              = rsp_st_ff;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the RTD bridge code-to-temperature core. Requests are sent
// with random gaps and the response side stalls at random. Each accepted
// request is predicted from a local fixed-point model and checked in order
// against the responses. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module tb_top;
   import rtdb_pkg::*;

   localparam int LATENCY_WAIT = 90;
   localparam int STALL_LIMIT  = 3000;
   localparam int IDLE_PCT     = 19;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 8'd9;

   typedef struct packed {
      logic [TEMP_W-1:0]   temp;
      logic [STATUS_W-1:0] status;
   } temp_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   int   stall_count = 0;
   bit   idle_on = 1'b1;

   temp_rsp_type temp_queue[$];

   logic [GAIN_W-1:0]   cfg_gain;
   logic [RES_W-1:0]    cfg_bridge;
   logic [RES_W-1:0]    cfg_limit;
   logic [SUPPLY_W-1:0] cfg_supply;

   rtdb_req_if req_bus ();
   rtdb_rsp_if rsp_bus ();
   rtdb_csr_if csr_bus ();

   rtd_bridge_code_to_temperature_core #(.ADC_BITS(18)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned isqrt64(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic temp_rsp_type predict_temp(logic signed [ADC_CODE_W-1:0] code);
      longint unsigned raw, v, k, num, rqu, q, br, lr, sv;
      longint den, rq, d, n, t;
      temp_rsp_type res;
      res.temp   = INVALID_TEMP;
      res.status = STATUS_BAD;
      if (code[ADC_CODE_W-1]) return res;
      raw = {46'd0, code};
      br  = (cfg_bridge != 0) ? 64'(cfg_bridge) : 64'(BRIDGE_DFLT);
      lr  = (cfg_limit != 0) ? 64'(cfg_limit) : 64'(LIMIT_DFLT);
      sv  = (cfg_supply != 0) ? 64'(cfg_supply) : 64'(SUPPLY_DFLT);
      v   = ((raw * 125) >> 3) >> cfg_gain;
      k   = (lr + br) / br;
      num = 2 * v * (3 * lr + br) + sv * br * 1000000;
      den = longint'(sv * 1000000) - longint'(2 * k * v);
      if (den <= 0) return res;
      rqu = (num * 65536 + longint'(unsigned'(den) / 2)) / longint'(unsigned'(den));
      if (rqu > 64'h7FFF_FFFF) rqu = 64'h7FFF_FFFF;
      rq = longint'(rqu);
      d  = 64'sd97758776896000000 - 64'sd2255859375 * (rq - 64'sd6553600);
      if (d < 0) begin
         res.status = STATUS_NEG_DISC;
         return res;
      end
      q = isqrt64(longint'(unsigned'(d)) * 64);
      n = (64'sd2501312000 - longint'(q)) * 5;
      if (n >= 0) t = (n + 1848) / 3696;
      else t = -((-n + 1848) / 3696);
      if (t > 1000000) t = 1000000;
      if (t < -250000) t = -250000;
      res.temp   = t[TEMP_W-1:0];
      res.status = STATUS_OK;
      return res;
   endfunction

   // response side: random stalls
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = !(idle_on && ($urandom_range(99) < IDLE_PCT));
      end
   end

   // response checker and watchdog
   always @(posedge clock) begin
      temp_rsp_type exp_rsp;
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            stall_count <= 0;
         else
            stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (temp_queue.size() == 0) begin
               $error("unexpected response temp=%0d status=%0d",
                      rsp_bus.temperature_milli_c, rsp_bus.status);
               errors++;
            end else begin
               exp_rsp = temp_queue.pop_front();
               if (rsp_bus.temperature_milli_c !== exp_rsp.temp) begin
                  $error("temperature_milli_c expected %0d actual %0d",
                         $signed(exp_rsp.temp), rsp_bus.temperature_milli_c);
                  errors++;
               end
               if (rsp_bus.status !== exp_rsp.status) begin
                  $error("status expected %0d actual %0d", exp_rsp.status, rsp_bus.status);
                  errors++;
               end
            end
         end
      end
   end

   task automatic send_code(logic signed [ADC_CODE_W-1:0] code);
      while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.adc_code = code;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      temp_queue.push_back(predict_temp(code));
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic wait_drain();
      while (temp_queue.size() != 0) @(negedge clock);
      repeat (LATENCY_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      wait_drain();
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.wdata = val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_GAIN:   cfg_gain   = val[GAIN_W-1:0];
         CSR_BRIDGE: cfg_bridge = val;
         CSR_LIMIT:  cfg_limit  = val;
         CSR_SUPPLY: cfg_supply = val[SUPPLY_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_config(int g, int br, int lr, int sv);
      write_reg(CSR_GAIN, CSR_DATA_W'(g));
      write_reg(CSR_BRIDGE, CSR_DATA_W'(br));
      write_reg(CSR_LIMIT, CSR_DATA_W'(lr));
      write_reg(CSR_SUPPLY, CSR_DATA_W'(sv));
   endtask

   task automatic test_directed_codes();
      send_code(18'sd0);
      send_code(18'sd1);
      send_code(18'sd131071);
      send_code(-18'sd1);
      send_code(-18'sd131072);
      send_code(18'sd65536);
      send_code(18'sd2000);
      send_code(18'sd20000);
      send_code(18'sd40000);
   endtask

   // zero registers fall back to defaults; unknown index and wide data ignored
   task automatic test_register_corners();
      set_config(16'hFFFF, 0, 0, 16'hFFF0);
      write_reg(CSR_UNUSED, 16'h1234);
      send_code(18'sd5000);
      send_code(18'sd131071);
      // huge ratio drives the denominator negative
      set_config(0, 1, 65535, 1);
      send_code(18'sd131071);
      send_code(18'sd100);
      send_code(18'sd0);
      // large resistance: saturated resistance and negative discriminant
      set_config(0, 65535, 1, 15);
      send_code(18'sd131071);
      send_code(18'sd60000);
      send_code(18'sd0);
      set_config(3, 65535, 65535, 15);
      send_code(18'sd131071);
      send_code(18'sd1);
   endtask

   task automatic test_random(int n_items);
      int i;
      logic signed [ADC_CODE_W-1:0] code;
      for (i = 0; i < n_items; i++) begin
         if (i % 150 == 0) begin
            if ($urandom_range(3) == 0)
               set_config($urandom_range(3), $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(15));
            else
               set_config($urandom_range(3), $urandom_range(1, 400), $urandom_range(100, 5000),
                          $urandom_range(1, 15));
         end
         idle_on = !(i >= 500 && i < 700);
         if (i == 900) wait_drain();
         case ($urandom_range(9))
            0:       code = ADC_CODE_W'($urandom);
            1:       code = -$signed({1'b0, 17'($urandom)});
            2, 3:    code = ADC_CODE_W'($urandom_range(131071));
            default: code = ADC_CODE_W'($urandom_range(60000));
         endcase
         send_code(code);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.adc_code = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_GAIN;
      csr_bus.wdata    = '0;
      cfg_gain   = '0;
      cfg_bridge = BRIDGE_DFLT;
      cfg_limit  = LIMIT_DFLT;
      cfg_supply = SUPPLY_DFLT;
      repeat (4) @(negedge clock);
      reset = 1'b0;
      test_directed_codes();
      test_register_corners();
      test_random(1300);
      wait_drain();
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
design/rtdb_pkg.sv
design/rtdb_if.sv
design/rtdb_div.sv
design/rtdb_sqrt.sv
design/rtd_bridge_code_to_temperature_core.sv
sim/tb_top.sv
